FILE: src/clnib_pkg.sv
package clnib_pkg;

    // Request opcodes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_CHAR   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_BUSY   = 3'd4;

    // Pin action codes
    localparam logic [2:0] ACT_NIBBLE     = 3'd0;
    localparam logic [2:0] ACT_DELAY      = 3'd1;
    localparam logic [2:0] ACT_START_POLL = 3'd2;
    localparam logic [2:0] ACT_POLL       = 3'd3;
    localparam logic [2:0] ACT_RELEASE    = 3'd4;
    localparam logic [2:0] ACT_ERROR      = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_POWERON_WAIT = 2'd0;
    localparam logic [1:0] CFG_CHAR_SETTLE  = 2'd1;
    localparam logic [1:0] CFG_CLEAR_SETTLE = 2'd2;

    localparam logic [15:0] POWERON_WAIT_RST = 16'd50000;
    localparam logic [15:0] CHAR_SETTLE_RST  = 16'd50000;
    localparam logic [15:0] CLEAR_SETTLE_RST = 16'd2000;

    // Job queue depth (power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Front-end protocol phase
    typedef enum logic {
        PHASE_IDLE,
        PHASE_POLL
    } phase_t;

    // Micro-ops walked by the back end, one pin action each
    typedef enum logic [4:0] {
        UOP_ERR,
        UOP_POLL,
        UOP_RELEASE,
        UOP_CLR_DLY,
        UOP_PWR_DLY,
        UOP_W3A,
        UOP_D10K,
        UOP_W3B,
        UOP_D100,
        UOP_W3C,
        UOP_W2,
        UOP_CMD_HI,
        UOP_CMD_LO,
        UOP_START_POLL,
        UOP_CHR_HI,
        UOP_CHR_LO,
        UOP_CHR_DLY,
        UOP_DONE
    } uop_t;

    typedef struct packed {
        uop_t       start_uop;
        logic [7:0] data;      // command or character byte
        logic       with_clr;  // release followed by clear settle delay
        logic       with_cmd;  // release followed by next init command
    } job_t;

    typedef struct packed {
        logic [15:0] poweron_wait_us;
        logic [15:0] char_settle_us;
        logic [15:0] clear_settle_us;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: src/clnib_front.sv
module clnib_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [2:0]          opcode,
    input  logic [7:0]          value,
    input  logic [1:0]          row,
    input  logic [5:0]          column,
    input  logic                busy_req,
    output clnib_pkg::job_t     job
);

    clnib_pkg::phase_t phase_reg, phase_next;
    logic [2:0] init_step_reg, init_step_next;
    logic       clear_pending_reg, clear_pending_next;
    logic [2:0] step_norm;
    logic [7:0] init_byte;
    logic [7:0] cursor_addr;

    assign step_norm = (init_step_reg > 3'd4) ? 3'd0 : init_step_reg;

    // Remaining init commands after the function-set
    always_comb begin
        case (step_norm)
            3'd1:    init_byte = 8'h08;
            3'd2:    init_byte = 8'h01;
            3'd3:    init_byte = 8'h06;
            3'd4:    init_byte = 8'h0F;
            default: init_byte = 8'h28;
        endcase
    end

    assign cursor_addr = 8'h80 + {2'b00, column} + (row[0] ? 8'h40 : 8'h00);

    always_comb begin
        phase_next         = phase_reg;
        init_step_next     = step_norm;
        clear_pending_next = clear_pending_reg;
        job.start_uop      = clnib_pkg::UOP_ERR;
        job.data           = 8'h00;
        job.with_clr       = 1'b0;
        job.with_cmd       = 1'b0;

        if (phase_reg == clnib_pkg::PHASE_POLL) begin
            if (opcode != clnib_pkg::OP_BUSY) begin
                job.start_uop = clnib_pkg::UOP_ERR;
            end else if (busy_req) begin
                job.start_uop = clnib_pkg::UOP_POLL;
            end else begin
                job.start_uop      = clnib_pkg::UOP_RELEASE;
                job.with_clr       = clear_pending_reg;
                clear_pending_next = 1'b0;
                phase_next         = clnib_pkg::PHASE_IDLE;
                if (step_norm != 3'd0) begin
                    job.with_cmd   = 1'b1;
                    job.data       = init_byte;
                    init_step_next = (step_norm == 3'd4) ? 3'd0 : step_norm + 3'd1;
                    if (init_byte == 8'h01) begin
                        clear_pending_next = 1'b1;
                    end
                    phase_next = clnib_pkg::PHASE_POLL;
                end
            end
        end else begin
            phase_next = clnib_pkg::PHASE_IDLE;
            case (opcode)
                clnib_pkg::OP_INIT: begin
                    job.start_uop      = clnib_pkg::UOP_PWR_DLY;
                    job.data           = 8'h28;
                    clear_pending_next = 1'b0;
                    init_step_next     = 3'd1;
                    phase_next         = clnib_pkg::PHASE_POLL;
                end
                clnib_pkg::OP_CMD: begin
                    job.start_uop = clnib_pkg::UOP_CMD_HI;
                    job.data      = value;
                    if (value == 8'h01) begin
                        clear_pending_next = 1'b1;
                    end
                    phase_next = clnib_pkg::PHASE_POLL;
                end
                clnib_pkg::OP_CHAR: begin
                    job.start_uop = clnib_pkg::UOP_CHR_HI;
                    job.data      = value;
                end
                clnib_pkg::OP_CURSOR: begin
                    if (row <= 2'd1 && column <= 6'd39) begin
                        job.start_uop = clnib_pkg::UOP_CMD_HI;
                        job.data      = cursor_addr;
                        phase_next    = clnib_pkg::PHASE_POLL;
                    end else begin
                        job.start_uop = clnib_pkg::UOP_ERR;
                    end
                end
                default: begin
                    job.start_uop = clnib_pkg::UOP_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= clnib_pkg::PHASE_IDLE;
            init_step_reg     <= 3'd0;
            clear_pending_reg <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            init_step_reg     <= init_step_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

endmodule

FILE: src/clnib_queue.sv
module clnib_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  clnib_pkg::job_t       push_job,
    input  logic                  pop,
    output clnib_pkg::job_t       head,
    output clnib_pkg::q_status_t  status
);

    clnib_pkg::job_t           mem [clnib_pkg::QDEPTH];
    logic [clnib_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [clnib_pkg::QPTR_W:0]   count_reg, count_next;

    assign status.full  = (count_reg == (clnib_pkg::QPTR_W+1)'(clnib_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/clnib_back.sv
module clnib_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  clnib_pkg::cfg_t       cfg,
    input  clnib_pkg::job_t       head,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_action,
    output logic                  m_reg_select,
    output logic                  m_read_write,
    output logic [3:0]            m_nibble,
    output logic [15:0]           m_wait_us,
    output logic                  m_last
);

    logic            busy_reg;
    clnib_pkg::uop_t uop_reg;
    clnib_pkg::uop_t uop_cur, uop_next;
    logic            out_free, emit, is_last;
    logic            m_valid_reg;
    logic [2:0]      act;
    logic            rs, rw;
    logic [3:0]      nib;
    logic [15:0]     dly;

    assign uop_cur  = busy_reg ? uop_reg : head.start_uop;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = !q_empty && out_free;
    assign is_last  = (uop_next == clnib_pkg::UOP_DONE);
    assign pop      = emit && is_last;

    // Sequence order; release branches on the job flags
    always_comb begin
        case (uop_cur)
            clnib_pkg::UOP_RELEASE: begin
                if (head.with_clr) begin
                    uop_next = clnib_pkg::UOP_CLR_DLY;
                end else if (head.with_cmd) begin
                    uop_next = clnib_pkg::UOP_CMD_HI;
                end else begin
                    uop_next = clnib_pkg::UOP_DONE;
                end
            end
            clnib_pkg::UOP_CLR_DLY: begin
                uop_next = head.with_cmd ? clnib_pkg::UOP_CMD_HI : clnib_pkg::UOP_DONE;
            end
            clnib_pkg::UOP_PWR_DLY:  uop_next = clnib_pkg::UOP_W3A;
            clnib_pkg::UOP_W3A:      uop_next = clnib_pkg::UOP_D10K;
            clnib_pkg::UOP_D10K:     uop_next = clnib_pkg::UOP_W3B;
            clnib_pkg::UOP_W3B:      uop_next = clnib_pkg::UOP_D100;
            clnib_pkg::UOP_D100:     uop_next = clnib_pkg::UOP_W3C;
            clnib_pkg::UOP_W3C:      uop_next = clnib_pkg::UOP_W2;
            clnib_pkg::UOP_W2:       uop_next = clnib_pkg::UOP_CMD_HI;
            clnib_pkg::UOP_CMD_HI:   uop_next = clnib_pkg::UOP_CMD_LO;
            clnib_pkg::UOP_CMD_LO:   uop_next = clnib_pkg::UOP_START_POLL;
            clnib_pkg::UOP_CHR_HI:   uop_next = clnib_pkg::UOP_CHR_LO;
            clnib_pkg::UOP_CHR_LO:   uop_next = clnib_pkg::UOP_CHR_DLY;
            default:                 uop_next = clnib_pkg::UOP_DONE;
        endcase
    end

    // Pin action for the current micro-op
    always_comb begin
        act = clnib_pkg::ACT_ERROR;
        rs  = 1'b0;
        rw  = 1'b0;
        nib = 4'h0;
        dly = 16'd0;
        case (uop_cur)
            clnib_pkg::UOP_POLL: begin
                act = clnib_pkg::ACT_POLL;
                rw  = 1'b1;
            end
            clnib_pkg::UOP_RELEASE: act = clnib_pkg::ACT_RELEASE;
            clnib_pkg::UOP_CLR_DLY: begin
                act = clnib_pkg::ACT_DELAY;
                dly = cfg.clear_settle_us;
            end
            clnib_pkg::UOP_PWR_DLY: begin
                act = clnib_pkg::ACT_DELAY;
                dly = cfg.poweron_wait_us;
            end
            clnib_pkg::UOP_W3A, clnib_pkg::UOP_W3B, clnib_pkg::UOP_W3C: begin
                act = clnib_pkg::ACT_NIBBLE;
                nib = 4'h3;
            end
            clnib_pkg::UOP_D10K: begin
                act = clnib_pkg::ACT_DELAY;
                dly = 16'd10000;
            end
            clnib_pkg::UOP_D100: begin
                act = clnib_pkg::ACT_DELAY;
                dly = 16'd100;
            end
            clnib_pkg::UOP_W2: begin
                act = clnib_pkg::ACT_NIBBLE;
                nib = 4'h2;
            end
            clnib_pkg::UOP_CMD_HI: begin
                act = clnib_pkg::ACT_NIBBLE;
                nib = head.data[7:4];
            end
            clnib_pkg::UOP_CMD_LO: begin
                act = clnib_pkg::ACT_NIBBLE;
                nib = head.data[3:0];
            end
            clnib_pkg::UOP_START_POLL: begin
                act = clnib_pkg::ACT_START_POLL;
                rw  = 1'b1;
            end
            clnib_pkg::UOP_CHR_HI: begin
                act = clnib_pkg::ACT_NIBBLE;
                rs  = 1'b1;
                nib = head.data[7:4];
            end
            clnib_pkg::UOP_CHR_LO: begin
                act = clnib_pkg::ACT_NIBBLE;
                rs  = 1'b1;
                nib = head.data[3:0];
            end
            clnib_pkg::UOP_CHR_DLY: begin
                act = clnib_pkg::ACT_DELAY;
                rs  = 1'b1;
                dly = cfg.char_settle_us;
            end
            default: act = clnib_pkg::ACT_ERROR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            uop_reg     <= clnib_pkg::UOP_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                busy_reg    <= !is_last;
                uop_reg     <= uop_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_action     <= act;
            m_reg_select <= rs;
            m_read_write <= rw;
            m_nibble     <= nib;
            m_wait_us    <= dly;
            m_last       <= is_last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: src/char_lcd_nibble_interface.sv
// Character LCD controller for a 4-bit HD44780-type bus. Each request beat
// (init, command, character, set cursor, busy sample) is turned into a run
// of pin-action beats on the m_ side: nibble strobes with RS/RW, delays in
// microseconds, busy-poll start and poll strobes, bus release, or an error.
// The final action of a request carries m_last. The front end classifies a
// request and updates the protocol state (poll phase, init progress, pending
// clear) in the cycle it is accepted; the job then sits in a two-entry queue
// until the back end plays it out at one action per cycle unless m_ready
// stalls the output. A request yields 1 action for errors and poll strobes,
// 3 for a command or character, up to 10 for init; the action sequencer is
// the limit. New requests are taken whenever the queue has room, also while
// earlier actions are still waiting at the output. Delay registers are
// written via cfg_we/cfg_index/cfg_wdata; the user must do so only while the
// block is idle, which the block does not enforce. An index beyond the list is ignored.
module char_lcd_nibble_interface (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_value,
    input  logic [1:0]  s_row,
    input  logic [5:0]  s_column,
    input  logic        s_busy_req,

    // action channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic        m_reg_select,
    output logic        m_read_write,
    output logic [3:0]  m_nibble,
    output logic [15:0] m_wait_us,
    output logic        m_last
);

    clnib_pkg::cfg_t      cfg_reg;
    clnib_pkg::job_t      new_job;
    clnib_pkg::job_t      head_job;
    clnib_pkg::q_status_t q_status;
    logic                 accept;
    logic                 pop;

    // front end takes a beat whenever the job queue has a free slot
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // delay registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poweron_wait_us <= clnib_pkg::POWERON_WAIT_RST;
            cfg_reg.char_settle_us  <= clnib_pkg::CHAR_SETTLE_RST;
            cfg_reg.clear_settle_us <= clnib_pkg::CLEAR_SETTLE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                clnib_pkg::CFG_POWERON_WAIT: cfg_reg.poweron_wait_us <= cfg_wdata;
                clnib_pkg::CFG_CHAR_SETTLE:  cfg_reg.char_settle_us  <= cfg_wdata;
                clnib_pkg::CFG_CLEAR_SETTLE: cfg_reg.clear_settle_us <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify request, track poll/init state
    clnib_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .opcode   (s_opcode),
        .value    (s_value),
        .row      (s_row),
        .column   (s_column),
        .busy_req (s_busy_req),
        .job      (new_job)
    );

    // decouples request acceptance from action playback
    clnib_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_job (new_job),
        .pop      (pop),
        .head     (head_job),
        .status   (q_status)
    );

    // action sequencer with registered output
    clnib_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head         (head_job),
        .q_empty      (q_status.empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_reg_select (m_reg_select),
        .m_read_write (m_read_write),
        .m_nibble     (m_nibble),
        .m_wait_us    (m_wait_us),
        .m_last       (m_last)
    );

endmodule
